// ===== rtl/farbfeld_stream_scaled_blitter_defines.svh =====
// assertion helpers used by the blitter rtl
`ifndef FARBFELD_STREAM_SCALED_BLITTER_DEFINES_SVH
`define FARBFELD_STREAM_SCALED_BLITTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FFB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffb assertion failed");

// antecedent implies consequent in the next cycle
`define FFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffb assertion failed");

// antecedent implies a delayed consequent
`define FFB_ASSERT_AFTER3(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error("ffb assertion failed");

`endif

// ===== rtl/ffb_pkg.sv =====
package ffb_pkg;

  localparam int WORD_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int INV_W       = 17;
  localparam int OFFS_W      = 16;
  localparam int DIM_W       = 13;
  localparam int STRIDE_W    = 16;
  localparam int FMT_W       = 2;
  localparam int ADDR_W      = 28;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  // four bytes per framebuffer pixel
  localparam int PIXEL_SHIFT = 2;

  // "farbfeld" in ascii
  localparam logic [WORD_W-1:0] MAGIC_WORD = 64'h6661726266656C64;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_NONE      = 2'd0;
  localparam kind_t KIND_PIXEL     = 2'd1;
  localparam kind_t KIND_HEADER    = 2'd2;
  localparam kind_t KIND_BAD_MAGIC = 2'd3;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_INV_SCALE   = 3'd0;
  localparam reg_idx_t REG_VERT_OFF    = 3'd1;
  localparam reg_idx_t REG_HORIZ_OFF   = 3'd2;
  localparam reg_idx_t REG_DISP_WIDTH  = 3'd3;
  localparam reg_idx_t REG_DISP_HEIGHT = 3'd4;
  localparam reg_idx_t REG_LINE_STRIDE = 3'd5;
  localparam reg_idx_t REG_PIXEL_FMT   = 3'd6;

  typedef logic [FMT_W-1:0] fmt_t;
  localparam fmt_t FMT_RGB = 2'd0;
  localparam fmt_t FMT_BGR = 2'd1;

  typedef struct packed {
    logic [INV_W-1:0]           inv_scale;
    logic signed [OFFS_W-1:0]   vert_off;
    logic [OFFS_W-1:0]          horiz_off;
    logic [DIM_W-1:0]           disp_width;
    logic [DIM_W-1:0]           disp_height;
    logic [STRIDE_W-1:0]        line_stride;
    fmt_t                       pixel_format;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    inv_scale:    17'd65536,
    vert_off:     16'sd0,
    horiz_off:    16'd0,
    disp_width:   13'd640,
    disp_height:  13'd480,
    line_stride:  16'd2560,
    pixel_format: FMT_RGB
  };

endpackage

// ===== rtl/ffb_in_if.sv =====
interface ffb_in_if import ffb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              start_of_image;

  modport source (output valid, output data_word, output start_of_image, input ready);
  modport sink   (input valid, input data_word, input start_of_image, output ready);
endinterface

// ===== rtl/ffb_out_if.sv =====
interface ffb_out_if import ffb_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              result_kind;
  logic [ADDR_W-1:0]  fb_address;
  logic [BYTE_W-1:0]  lane_zero;
  logic [BYTE_W-1:0]  lane_one;
  logic [BYTE_W-1:0]  lane_two;
  logic [COUNT_W-1:0] image_width;
  logic [COUNT_W-1:0] image_height;

  modport source (output valid, output result_kind, output fb_address, output lane_zero,
                  output lane_one, output lane_two, output image_width,
                  output image_height, input ready);
  modport sink   (input valid, input result_kind, input fb_address, input lane_zero,
                  input lane_one, input lane_two, input image_width,
                  input image_height, output ready);
endinterface

// ===== rtl/ffb_cfg.sv =====
module ffb_cfg import ffb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_SCALE:   regs_r.inv_scale    <= cfg_data[INV_W-1:0];
        REG_VERT_OFF:    regs_r.vert_off     <= $signed(cfg_data[OFFS_W-1:0]);
        REG_HORIZ_OFF:   regs_r.horiz_off    <= cfg_data[OFFS_W-1:0];
        REG_DISP_WIDTH:  regs_r.disp_width   <= cfg_data[DIM_W-1:0];
        REG_DISP_HEIGHT: regs_r.disp_height  <= cfg_data[DIM_W-1:0];
        REG_LINE_STRIDE: regs_r.line_stride  <= cfg_data[STRIDE_W-1:0];
        REG_PIXEL_FMT:   regs_r.pixel_format <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/ffb_mul.sv =====
module ffb_mul #(
  parameter int A_W = 32,
  parameter int B_W = 17
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   p_r
);

  // registered product, held while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule

// ===== rtl/farbfeld_stream_scaled_blitter.sv =====
// pixel request: accepted in idle, then col, addr and out in turn; no new word is accepted
// until out hands the result on; header and ignored words go from idle straight to out
// one 32x17 multiplier serves row scale, column scale and row-times-stride in turn
// a result waiting at the output stalls only the final step of the following request
// synchronous active-low reset: counters, stream phase and held size cleared,
// config registers back to their defaults, output empty
`include "farbfeld_stream_scaled_blitter_defines.svh"

module farbfeld_stream_scaled_blitter import ffb_pkg::*; #(
  parameter int MAX_DISPLAY_DIM = 4096,
  parameter int SCALE_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ffb_in_if.sink                in_ch,
  ffb_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // product of a counter and the reciprocal scale
  localparam int PROD_W    = COUNT_W + INV_W;
  // floored scaled coordinate
  localparam int SC_W      = PROD_W - SCALE_FRAC_BITS;
  // room for the offset and a sign bit
  localparam int POS_W     = SC_W + 2;
  localparam int LIM_RAW_W = $clog2(MAX_DISPLAY_DIM + 1);
  localparam int LIM_W     = (LIM_RAW_W > DIM_W) ? LIM_RAW_W : DIM_W;

  // sequencer: idle takes a request, col and addr run the shared multiplier,
  // out hands the result to the output register
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COL  = 4'b0010,
    ST_ADDR = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // stream phase: waiting for magic, waiting for the size word, taking pixels
  typedef enum logic [2:0] {
    PH_MAGIC  = 3'b001,
    PH_DIMS   = 3'b010,
    PH_PIXELS = 3'b100
  } phase_t;

  cfg_regs_t cfg;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [COUNT_W-1:0] col_r, col_nxt;
  logic [COUNT_W-1:0] row_r, row_nxt;
  logic [COUNT_W-1:0] held_w_r, held_w_nxt;
  logic [COUNT_W-1:0] held_h_r, held_h_nxt;

  kind_t pend_kind_r, pend_kind_nxt;
  logic  pix_r, pix_nxt;

  // pixel bytes b0, b2 and b4 of the request word
  logic [BYTE_W-1:0] b0_r, b2_r, b4_r;

  logic [DIM_W-1:0] dy_r;
  logic             dy_ok_r;
  logic [DIM_W-1:0] dx_r;
  logic             inside_r;

  logic                accept;
  logic                out_free;
  logic                out_load;

  logic [COUNT_W-1:0]  mul_a;
  logic [INV_W-1:0]    mul_b;
  logic                mul_en;
  logic [PROD_W-1:0]   prod_r;

  logic [LIM_W-1:0]    lim_w;
  logic [LIM_W-1:0]    lim_h;
  logic [SC_W-1:0]     sc;
  logic [POS_W-1:0]    dy_full;
  logic [POS_W-1:0]    dx_full;
  logic                dy_ok;
  logic                dx_ok;

  logic [COUNT_W-1:0]  col_inc;
  logic                col_wrap;
  logic [COUNT_W-1:0]  col_adv;
  logic [COUNT_W-1:0]  row_adv;

  logic                fmt_ok;
  kind_t               res_kind;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [BYTE_W-1:0]   out_l0_r, out_l1_r, out_l2_r;
  logic [COUNT_W-1:0]  out_w_r, out_h_r;

  // configuration registers
  ffb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  // handshakes
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_load    = (state_r == ST_OUT) && out_free;

  // shared multiplier operand select
  // idle keeps row times scale ready so it is in place at acceptance,
  // col forms column times scale, addr forms display row times stride
  always_comb begin
    mul_a = row_r;
    mul_b = cfg.inv_scale;
    unique case (state_r)
      ST_COL: begin
        mul_a = col_r;
      end
      ST_ADDR: begin
        mul_a = COUNT_W'(dy_r);
        mul_b = INV_W'(cfg.line_stride);
      end
      default: ;
    endcase
  end

  // hold the stride product while the result waits at the output
  assign mul_en = (state_r != ST_OUT);

  ffb_mul #(
    .A_W (COUNT_W),
    .B_W (INV_W)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // clip limits, display size capped at the largest supported display
  assign lim_w = (LIM_W'(cfg.disp_width) < LIM_W'(MAX_DISPLAY_DIM)) ?
                 LIM_W'(cfg.disp_width) : LIM_W'(MAX_DISPLAY_DIM);
  assign lim_h = (LIM_W'(cfg.disp_height) < LIM_W'(MAX_DISPLAY_DIM)) ?
                 LIM_W'(cfg.disp_height) : LIM_W'(MAX_DISPLAY_DIM);

  // floor of the scaled coordinate, then the offsets
  assign sc      = prod_r[PROD_W-1:SCALE_FRAC_BITS];
  assign dy_full = {2'b00, sc} + {{(POS_W-OFFS_W){cfg.vert_off[OFFS_W-1]}}, cfg.vert_off};
  assign dx_full = {2'b00, sc} - {{(POS_W-OFFS_W){1'b0}}, cfg.horiz_off};
  assign dy_ok   = !dy_full[POS_W-1] && (dy_full[POS_W-2:0] < (POS_W-1)'(lim_h));
  assign dx_ok   = !dx_full[POS_W-1] && (dx_full[POS_W-2:0] < (POS_W-1)'(lim_w));

  // coordinate stage registers
  always_ff @(posedge clk) begin
    if (accept) begin
      b0_r <= in_ch.data_word[63:56];
      b2_r <= in_ch.data_word[47:40];
      b4_r <= in_ch.data_word[31:24];
    end
    if (state_r == ST_COL) begin
      dy_r    <= dy_full[DIM_W-1:0];
      dy_ok_r <= dy_ok;
    end
    if (state_r == ST_ADDR) begin
      dx_r     <= dx_full[DIM_W-1:0];
      inside_r <= dy_ok_r && dx_ok && (row_r < held_h_r);
    end
  end

  // counter advance after a pixel, column and row saturate at all ones
  assign col_inc  = (col_r != '1) ? col_r + COUNT_W'(1) : col_r;
  assign col_wrap = (col_inc >= held_w_r);
  assign col_adv  = col_wrap ? '0 : col_inc;
  assign row_adv  = (col_wrap && (row_r != '1)) ? row_r + COUNT_W'(1) : row_r;

  // sequencer and stream phase
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    held_w_nxt    = held_w_r;
    held_h_nxt    = held_h_r;
    pend_kind_nxt = pend_kind_r;
    pix_nxt       = pix_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pix_nxt       = 1'b0;
          pend_kind_nxt = KIND_NONE;
          state_nxt     = ST_OUT;
          if (in_ch.start_of_image) begin
            // any marked word restarts the header check
            if (in_ch.data_word == MAGIC_WORD) begin
              phase_nxt = PH_DIMS;
            end else begin
              phase_nxt     = PH_MAGIC;
              pend_kind_nxt = KIND_BAD_MAGIC;
            end
          end else begin
            unique case (phase_r)
              PH_DIMS: begin
                held_w_nxt    = in_ch.data_word[63:32];
                held_h_nxt    = in_ch.data_word[31:0];
                col_nxt       = '0;
                row_nxt       = '0;
                phase_nxt     = PH_PIXELS;
                pend_kind_nxt = KIND_HEADER;
              end
              PH_PIXELS: begin
                pix_nxt   = 1'b1;
                state_nxt = ST_COL;
              end
              // unmarked word while waiting for magic is dropped
              default: ;
            endcase
          end
        end
      end
      ST_COL: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (pix_r) begin
            col_nxt = col_adv;
            row_nxt = row_adv;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= PH_MAGIC;
      col_r    <= '0;
      row_r    <= '0;
      held_w_r <= '0;
      held_h_r <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      held_w_r <= held_w_nxt;
      held_h_r <= held_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind_r <= pend_kind_nxt;
    pix_r       <= pix_nxt;
  end

  // result kind: pixels write only on the display and with a known layout
  assign fmt_ok   = (cfg.pixel_format == FMT_RGB) || (cfg.pixel_format == FMT_BGR);
  assign res_kind = pix_r ? ((inside_r && fmt_ok) ? KIND_PIXEL : KIND_NONE) : pend_kind_r;

  // output register, fields not belonging to the kind read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= res_kind;
      if (res_kind == KIND_PIXEL) begin
        // column times four plus row times stride, wrapping at the address width
        out_addr_r <= prod_r[ADDR_W-1:0] + ADDR_W'({dx_r, {PIXEL_SHIFT{1'b0}}});
        out_l0_r   <= (cfg.pixel_format == FMT_RGB) ? b4_r : b0_r;
        out_l1_r   <= b2_r;
        out_l2_r   <= (cfg.pixel_format == FMT_RGB) ? b0_r : b4_r;
      end else begin
        out_addr_r <= '0;
        out_l0_r   <= '0;
        out_l1_r   <= '0;
        out_l2_r   <= '0;
      end
      if (res_kind == KIND_HEADER) begin
        out_w_r <= held_w_r;
        out_h_r <= held_h_r;
      end else begin
        out_w_r <= '0;
        out_h_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.fb_address   = out_addr_r;
  assign out_ch.lane_zero    = out_l0_r;
  assign out_ch.lane_one     = out_l1_r;
  assign out_ch.lane_two     = out_l2_r;
  assign out_ch.image_width  = out_w_r;
  assign out_ch.image_height = out_h_r;

  // checks
  `FFB_ASSERT_IMPL(a_pixel_fields_zero, out_ch.valid && (out_ch.result_kind != KIND_PIXEL), (out_ch.fb_address == '0) && (out_ch.lane_zero == '0) && (out_ch.lane_one == '0) && (out_ch.lane_two == '0))
  `FFB_ASSERT_IMPL(a_size_fields_zero, out_ch.valid && (out_ch.result_kind != KIND_HEADER), (out_ch.image_width == '0) && (out_ch.image_height == '0))
  `FFB_ASSERT_AFTER3(a_pixel_reaches_out, accept && !in_ch.start_of_image && (phase_r == PH_PIXELS), state_r == ST_OUT)
  `FFB_ASSERT_NEXT(a_size_word_clears, accept && !in_ch.start_of_image && (phase_r == PH_DIMS), (col_r == '0) && (row_r == '0) && (phase_r == PH_PIXELS))

endmodule
